// ===== hdl/double_hash_bucket_placement_unit_macros.svh =====
// Assertion macros used by the bucket placement top level.
`ifndef DOUBLE_HASH_BUCKET_PLACEMENT_UNIT_MACROS_SVH
`define DOUBLE_HASH_BUCKET_PLACEMENT_UNIT_MACROS_SVH

// Same-cycle implication, sampled on clk, off while rst_n is low.
`define DHBP_ASSERT_IMP(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, sampled on clk, off while rst_n is low.
`define DHBP_ASSERT_NXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/dhbp_pkg.sv =====
// Shared constants and types of the double-hash bucket placement block.
`timescale 1ns / 1ps

package dhbp_pkg;

    // Sizing
    localparam int MAX_BUCKETS  = 64;
    localparam int MAX_CAPACITY = 1024;
    localparam int CHAR_W       = 7;
    localparam int BUCKET_W     = $clog2(MAX_BUCKETS);
    localparam int COUNT_W      = BUCKET_W + 1;
    localparam int CAP_W        = $clog2(MAX_CAPACITY + 1);
    localparam int STEPS_W      = COUNT_W;

    // Hash arithmetic: both products fit in DIV_W bits for any 7-bit checksum
    localparam int DIV_W        = 24;
    localparam int DIV_CNT_W    = $clog2(DIV_W);
    localparam logic [DIV_W-1:0] HASH_MUL1 = DIV_W'(7919);
    localparam logic [DIV_W-1:0] HASH_MUL2 = DIV_W'(104729);
    localparam logic [DIV_W-1:0] HASH_ADD2 = DIV_W'(123);
    localparam logic [CHAR_W-1:0] SPACE_CHAR = CHAR_W'(8'h20);

    // Configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = CAP_W;
    localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_COUNT    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_BUCKET_CAPACITY = CFG_IDX_W'(1);

    // Request to the hash remainder unit
    typedef struct packed {
        logic              go;
        logic [CHAR_W-1:0] x;
    } mod_req_t;

    // Result of the hash remainder unit
    typedef struct packed {
        logic                done;
        logic [BUCKET_W-1:0] home;
        logic [BUCKET_W-1:0] step;
    } mod_res_t;

endpackage

// ===== hdl/double_hash_bucket_placement_unit.sv =====
// Top level: checksum, configuration, probe sequencer and bucket fill memory.
//
// Usage:
//   A name enters one 7-bit character per beat on name_char, taken at a rising
//   edge where start is high and busy is low; last_char marks its final beat.
//   A beat without last_char leaves busy low.
//   The final beat raises busy while both hash products of the checksum are
//   reduced modulo the bucket count by a bit-serial remainder unit, one
//   dividend bit at a time; then the probe walk reads and checks the fill
//   memory, each probe going through S_READ and S_CHECK, as reads are registered.
//   The result beat appears on done and lasts exactly one cycle; busy falls
//   with it, so a beat of the next name can be taken while done is high.
//   Configuration beats on cfg_valid/cfg_ready are always taken (index 0:
//   bucket count, index 1: bucket capacity; other indexes are ignored) and
//   must only be sent while busy is low.
//   Reset clears the checksum, all fill counts (through per-bucket valid
//   flags, no clearing pass), and sets bucket count 1, capacity 0.
//   The receiver cannot stall: a result is shown for one cycle only.
`timescale 1ns / 1ps
`include "double_hash_bucket_placement_unit_macros.svh"

module double_hash_bucket_placement_unit (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            start,
    output logic                            busy,
    input  logic [dhbp_pkg::CHAR_W-1:0]     name_char,
    input  logic                            last_char,
    output logic                            done,
    output logic [dhbp_pkg::BUCKET_W-1:0]   home_bucket,
    output logic [dhbp_pkg::BUCKET_W-1:0]   chosen_bucket,
    output logic [dhbp_pkg::STEPS_W-1:0]    probe_steps,
    output logic                            placed,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [dhbp_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [dhbp_pkg::CFG_DATA_W-1:0] cfg_data
);
    import dhbp_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_DIV   = 4'b0010,
        S_READ  = 4'b0100,
        S_CHECK = 4'b1000
    } state_t;

    state_t               state_reg, state_next;
    logic [CHAR_W-1:0]    xor_reg, xor_next;
    logic [COUNT_W-1:0]   count_reg;
    logic [CAP_W-1:0]     cap_reg;
    logic [MAX_BUCKETS-1:0] valid_reg, valid_next;
    logic                 done_reg, done_next;
    logic                 placed_reg, placed_next;
    logic [BUCKET_W-1:0]  home_reg, home_next;
    logic [BUCKET_W-1:0]  step_reg, step_next;
    logic [BUCKET_W-1:0]  b_reg, b_next;
    logic [STEPS_W-1:0]   k_reg, k_next;

    logic                 accept;
    logic [CHAR_W-1:0]    xor_fold;
    logic [COUNT_W-1:0]   n_eff;
    logic [CAP_W-1:0]     cap_eff;
    logic [CAP_W-1:0]     ram_rdata;
    logic [CAP_W-1:0]     fill_cur;
    logic [CAP_W-1:0]     fill_inc;
    logic                 has_room;
    logic                 ram_we;
    logic                 ram_re;
    logic [COUNT_W-1:0]   b_sum;
    logic [BUCKET_W-1:0]  b_adv;
    mod_req_t             mod_req;
    mod_res_t             mod_res;

    assign accept    = start && !busy;
    assign cfg_ready = 1'b1;

    // Clamp the registers to their usable ranges
    always_comb
    begin
        if (count_reg == '0)
        begin
            n_eff = COUNT_W'(1);
        end
        else if (count_reg > COUNT_W'(MAX_BUCKETS))
        begin
            n_eff = COUNT_W'(MAX_BUCKETS);
        end
        else
        begin
            n_eff = count_reg;
        end
        cap_eff = (cap_reg > CAP_W'(MAX_CAPACITY)) ? CAP_W'(MAX_CAPACITY) : cap_reg;
    end

    // Fold the character into the checksum unless it is a space
    assign xor_fold = (name_char == SPACE_CHAR) ? xor_reg : (xor_reg ^ name_char);

    // Launch the remainder unit on the final character
    assign mod_req.go = accept && last_char;
    assign mod_req.x  = xor_fold;

    dhbp_hash_mod u_hash_mod (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mod_req),
        .n     (n_eff),
        .res   (mod_res)
    );

    // Fill count of the probed bucket; a bucket never written reads as empty.
    // A write lands only in S_CHECK and a read only in S_READ, so read and
    // write never overlap on one entry.
    assign fill_cur = valid_reg[b_reg] ? ram_rdata : '0;
    assign fill_inc = fill_cur + CAP_W'(1);
    assign has_room = fill_cur < cap_eff;
    assign ram_re   = (state_reg == S_READ);
    assign ram_we   = (state_reg == S_CHECK) && has_room;

    dhbp_ram #(
        .WIDTH (CAP_W),
        .DEPTH (MAX_BUCKETS)
    ) u_fill_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (b_reg),
        .wdata (fill_inc),
        .re    (ram_re),
        .raddr (b_reg),
        .rdata (ram_rdata)
    );

    // Next probe: step is already below n, so one subtract wraps the sum
    assign b_sum = COUNT_W'(b_reg) + COUNT_W'(step_reg);
    assign b_adv = (b_sum >= n_eff) ? BUCKET_W'(b_sum - n_eff) : b_sum[BUCKET_W-1:0];

    // Sequencer
    always_comb
    begin
        state_next  = state_reg;
        xor_next    = xor_reg;
        valid_next  = valid_reg;
        done_next   = 1'b0;
        placed_next = placed_reg;
        home_next   = home_reg;
        step_next   = step_reg;
        b_next      = b_reg;
        k_next      = k_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    if (last_char)
                    begin
                        xor_next   = '0;
                        state_next = S_DIV;
                    end
                    else
                    begin
                        xor_next = xor_fold;
                    end
                end
            end
            S_DIV:
            begin
                if (mod_res.done)
                begin
                    home_next  = mod_res.home;
                    step_next  = mod_res.step;
                    b_next     = mod_res.home;
                    k_next     = '0;
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                state_next = S_CHECK;
            end
            S_CHECK:
            begin
                if (has_room)
                begin
                    // Place the item and mark the bucket as written
                    valid_next[b_reg] = 1'b1;
                    placed_next       = 1'b1;
                    done_next         = 1'b1;
                    state_next        = S_IDLE;
                end
                else if (k_reg == n_eff + COUNT_W'(1))
                begin
                    // Drop: every probe found a full bucket
                    placed_next = 1'b0;
                    done_next   = 1'b1;
                    state_next  = S_IDLE;
                end
                else
                begin
                    k_next     = k_reg + STEPS_W'(1);
                    b_next     = b_adv;
                    state_next = S_READ;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            xor_reg    <= '0;
            valid_reg  <= '0;
            done_reg   <= 1'b0;
            placed_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            xor_reg    <= xor_next;
            valid_reg  <= valid_next;
            done_reg   <= done_next;
            placed_reg <= placed_next;
        end
    end

    // Configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= COUNT_W'(1);
            cap_reg   <= '0;
        end
        else if (cfg_valid && cfg_ready)
        begin
            if (cfg_index == CFG_BUCKET_COUNT)
            begin
                count_reg <= cfg_data[COUNT_W-1:0];
            end
            else if (cfg_index == CFG_BUCKET_CAPACITY)
            begin
                cap_reg <= cfg_data[CAP_W-1:0];
            end
        end
    end

    // Probe payload
    always_ff @(posedge clk)
    begin
        home_reg <= home_next;
        step_reg <= step_next;
        b_reg    <= b_next;
        k_reg    <= k_next;
    end

    // Result beat
    assign busy          = (state_reg != S_IDLE);
    assign done          = done_reg;
    assign home_bucket   = home_reg;
    assign chosen_bucket = placed_reg ? b_reg : '0;
    assign probe_steps   = k_reg;
    assign placed        = placed_reg;

    `DHBP_ASSERT_IMP(a_chosen_in_range, done_reg && placed_reg, COUNT_W'(b_reg) < n_eff, "placed bucket lies beyond the bucket count")
    `DHBP_ASSERT_IMP(a_drop_full_walk, done_reg && !placed_reg, k_reg == n_eff + COUNT_W'(1), "item dropped before the full probe walk")
    `DHBP_ASSERT_IMP(a_probe_bound, state_reg == S_CHECK, k_reg <= n_eff + COUNT_W'(1), "probe count ran past the bucket count plus one")
    `DHBP_ASSERT_NXT(a_room_places, (state_reg == S_CHECK) && has_room, done_reg && placed_reg && (state_reg == S_IDLE), "room found but no placement beat")

endmodule

// ===== hdl/dhbp_ram.sv =====
// Generic single-write, single-read synchronous RAM with registered read data.
`timescale 1ns / 1ps

module dhbp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== hdl/dhbp_hash_mod.sv =====
// Bit-serial remainder unit: reduces both hash products modulo the bucket count.
`timescale 1ns / 1ps

module dhbp_hash_mod (
    input  logic                          clk,
    input  logic                          rst_n,
    input  dhbp_pkg::mod_req_t            req,
    input  logic [dhbp_pkg::COUNT_W-1:0]  n,
    output dhbp_pkg::mod_res_t            res
);
    import dhbp_pkg::*;

    logic                 busy_reg, busy_next;
    logic                 done_reg, done_next;
    logic [DIV_CNT_W-1:0] cnt_reg, cnt_next;
    logic [DIV_W-1:0]     h1_reg, h1_next;
    logic [DIV_W-1:0]     h2_reg, h2_next;
    logic [BUCKET_W-1:0]  r1_reg, r1_next;
    logic [BUCKET_W-1:0]  r2_reg, r2_next;
    logic [COUNT_W-1:0]   t1, t2;

    // Shift in the next dividend bit; one subtract keeps each remainder below n
    assign t1 = {r1_reg, h1_reg[DIV_W-1]};
    assign t2 = {r2_reg, h2_reg[DIV_W-1]};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        h1_next   = h1_reg;
        h2_next   = h2_reg;
        r1_next   = r1_reg;
        r2_next   = r2_reg;
        if (req.go)
        begin
            // Load both products of the checksum
            busy_next = 1'b1;
            cnt_next  = '0;
            h1_next   = HASH_MUL1 * DIV_W'(req.x);
            h2_next   = HASH_MUL2 * DIV_W'(req.x) + HASH_ADD2;
            r1_next   = '0;
            r2_next   = '0;
        end
        else if (busy_reg)
        begin
            h1_next = {h1_reg[DIV_W-2:0], 1'b0};
            h2_next = {h2_reg[DIV_W-2:0], 1'b0};
            r1_next = (t1 >= n) ? BUCKET_W'(t1 - n) : t1[BUCKET_W-1:0];
            r2_next = (t2 >= n) ? BUCKET_W'(t2 - n) : t2[BUCKET_W-1:0];
            cnt_next = cnt_reg + DIV_CNT_W'(1);
            if (cnt_reg == DIV_CNT_W'(DIV_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        h1_reg <= h1_next;
        h2_reg <= h2_next;
        r1_reg <= r1_next;
        r2_reg <= r2_next;
    end

    assign res.done = done_reg;
    assign res.home = r1_reg;
    assign res.step = r2_reg;

endmodule

// ===== tb/double_hash_bucket_placement_checker.sv =====
// Checker that predicts bucket placements from observed beats and compares results.
`timescale 1ns / 1ps

module double_hash_bucket_placement_checker
    import dhbp_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic                  busy,
    input  logic [CHAR_W-1:0]     name_char,
    input  logic                  last_char,
    input  logic                  done,
    input  logic [BUCKET_W-1:0]   home_bucket,
    input  logic [BUCKET_W-1:0]   chosen_bucket,
    input  logic [STEPS_W-1:0]    probe_steps,
    input  logic                  placed,
    input  logic                  cfg_valid,
    input  logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    output int                    mismatch_total,
    output int                    placements_pending
);

    localparam longint HOME_MUL   = 7919;
    localparam longint STRIDE_MUL = 104729;
    localparam longint STRIDE_ADD = 123;
    localparam logic [CHAR_W-1:0] BLANK_CHAR = 7'h20;

    typedef struct packed {
        logic [BUCKET_W-1:0] home;
        logic [BUCKET_W-1:0] chosen;
        logic [STEPS_W-1:0]  steps;
        logic                stored;
    } placement_t;

    // Shadow state, touched only by the process below
    logic [CHAR_W-1:0] name_checksum;
    logic [CAP_W-1:0]  bucket_level [MAX_BUCKETS];
    logic [6:0]        count_setting;
    logic [CAP_W-1:0]  capacity_setting;
    placement_t        placement_q [$];
    int                miss_count;

    // Place one finished name: home bucket, then double-hash probe walk
    function automatic placement_t place_name(input logic [CHAR_W-1:0] x);
        placement_t r;
        longint     n;
        longint     cap;
        longint     h1;
        longint     h2;
        longint     b;
        r   = '0;
        n   = count_setting;
        cap = capacity_setting;
        if (n == 0)
            n = 1;
        if (n > MAX_BUCKETS)
            n = MAX_BUCKETS;
        if (cap > MAX_CAPACITY)
            cap = MAX_CAPACITY;
        h1 = HOME_MUL * longint'(x);
        h2 = STRIDE_MUL * longint'(x) + STRIDE_ADD;
        r.home = BUCKET_W'(h1 % n);
        if (longint'(bucket_level[r.home]) < cap)
        begin
            r.chosen = r.home;
            r.stored = 1'b1;
        end
        else
        begin
            for (longint k = 1; k <= n + 1; k++)
            begin
                b       = (h1 + k * h2) % n;
                r.steps = STEPS_W'(k);
                if (longint'(bucket_level[BUCKET_W'(b)]) < cap)
                begin
                    r.chosen = BUCKET_W'(b);
                    r.stored = 1'b1;
                    break;
                end
            end
        end
        // Bump the fill of the bucket that took the name
        if (r.stored)
            bucket_level[r.chosen] = bucket_level[r.chosen] + 1'b1;
        return r;
    endfunction

    function automatic int field_miss(input string field, input int want, input int got);
        if (want != got)
        begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, got);
            return 1;
        end
        return 0;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        placement_t want;
        if (!rst_n)
        begin
            name_checksum    = '0;
            count_setting    = 7'd1;
            capacity_setting = '0;
            miss_count       = 0;
            for (int i = 0; i < MAX_BUCKETS; i++)
                bucket_level[i] = '0;
            placement_q.delete();
            mismatch_total     <= 0;
            placements_pending <= 0;
        end
        else
        begin
            // Track register writes; unknown indexes are dropped
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_BUCKET_COUNT:    count_setting    = cfg_data[6:0];
                    CFG_BUCKET_CAPACITY: capacity_setting = cfg_data;
                    default: ;
                endcase
            end

            // Compare a result beat with the oldest placement waiting
            if (done)
            begin
                if (placement_q.size() == 0)
                begin
                    $error("result beat with no placement waiting: home %0d chosen %0d",
                           home_bucket, chosen_bucket);
                    miss_count++;
                end
                else
                begin
                    want = placement_q.pop_front();
                    miss_count += field_miss("home_bucket", want.home, home_bucket);
                    miss_count += field_miss("chosen_bucket", want.chosen, chosen_bucket);
                    miss_count += field_miss("probe_steps", want.steps, probe_steps);
                    miss_count += field_miss("placed", want.stored, placed);
                end
            end

            // Fold an accepted character beat into the checksum
            if (start && !busy)
            begin
                if (name_char != BLANK_CHAR)
                    name_checksum = name_checksum ^ name_char;
                if (last_char)
                begin
                    placement_q.push_back(place_name(name_checksum));
                    name_checksum = '0;
                end
            end

            mismatch_total     <= miss_count;
            placements_pending <= placement_q.size();
        end
    end

endmodule

// ===== tb/double_hash_bucket_placement_unit_test.sv =====
// Top of the bucket placement testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps

module double_hash_bucket_placement_unit_test;
    import dhbp_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam logic [CHAR_W-1:0]    BLANK_CHAR  = 7'h20;
    localparam int                   CHAR_BUDGET = 2000;

    logic                  clk         = 1'b0;
    logic                  rst_n       = 1'b0;
    logic                  start       = 1'b0;
    logic [CHAR_W-1:0]     name_char   = '0;
    logic                  last_char   = 1'b0;
    logic                  cfg_valid   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_index   = '0;
    logic [CFG_DATA_W-1:0] cfg_data    = '0;
    logic                  busy;
    logic                  done;
    logic [BUCKET_W-1:0]   home_bucket;
    logic [BUCKET_W-1:0]   chosen_bucket;
    logic [STEPS_W-1:0]    probe_steps;
    logic                  placed;
    logic                  cfg_ready;
    int                    mismatch_total;
    int                    placements_pending;

    int chars_sent = 0;
    bit quiet_phase = 1'b0;

    double_hash_bucket_placement_unit dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .name_char     (name_char),
        .last_char     (last_char),
        .done          (done),
        .home_bucket   (home_bucket),
        .chosen_bucket (chosen_bucket),
        .probe_steps   (probe_steps),
        .placed        (placed),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data)
    );

    double_hash_bucket_placement_checker placement_check (
        .clk                (clk),
        .rst_n              (rst_n),
        .start              (start),
        .busy               (busy),
        .name_char          (name_char),
        .last_char          (last_char),
        .done               (done),
        .home_bucket        (home_bucket),
        .chosen_bucket      (chosen_bucket),
        .probe_steps        (probe_steps),
        .placed             (placed),
        .cfg_valid          (cfg_valid),
        .cfg_ready          (cfg_ready),
        .cfg_index          (cfg_index),
        .cfg_data           (cfg_data),
        .mismatch_total     (mismatch_total),
        .placements_pending (placements_pending)
    );

    initial
    begin
        forever #5 clk = ~clk;
    end

    // Slowest correct run is about 2000 one-character names with full probe walks
    // and long gaps, roughly 4 ms; allow several times that.
    initial
    begin
        #20_000_000;
        $display("Verification failed");
        $finish;
    end

    // Hold start low for a random gap: mostly none, some short, a few long
    task automatic idle_gap();
        int pick;
        int gap;
        pick = $urandom_range(0, 99);
        gap  = 0;
        if (!quiet_phase)
        begin
            if (pick >= 95)
                gap = $urandom_range(8, 40);
            else if (pick >= 70)
                gap = $urandom_range(1, 3);
        end
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    // Present one character beat and hold it until taken
    task automatic send_char(input logic [CHAR_W-1:0] ch, input logic is_last);
        idle_gap();
        start     <= 1'b1;
        name_char <= ch;
        last_char <= is_last;
        do
            @(posedge clk);
        while (busy);
        chars_sent++;
    endtask

    // Send a name of random characters, spaces and extremes mixed in
    task automatic send_name(input int len);
        logic [CHAR_W-1:0] ch;
        int                pick;
        for (int i = 0; i < len; i++)
        begin
            pick = $urandom_range(0, 15);
            if (pick < 2)
                ch = BLANK_CHAR;
            else if (pick == 2)
                ch = '0;
            else if (pick == 3)
                ch = '1;
            else
                ch = CHAR_W'($urandom_range(0, 127));
            send_char(ch, i == len - 1);
        end
    endtask

    // Drop start and wait until every placement has come back
    task automatic drain();
        start <= 1'b0;
        @(posedge clk);
        while (placements_pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    // One configuration beat; valid stays high for a following beat
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do
            @(posedge clk);
        while (!cfg_ready);
    endtask

    task automatic configure(input logic [CFG_DATA_W-1:0] count, input logic [CFG_DATA_W-1:0] cap);
        write_reg(CFG_BUCKET_COUNT, count);
        if ($urandom_range(0, 3) == 0)
            write_reg($urandom_range(0, 1) ? CFG_SPARE_A : CFG_SPARE_B,
                      CFG_DATA_W'($urandom_range(0, 2047)));
        write_reg(CFG_BUCKET_CAPACITY, cap);
        cfg_valid <= 1'b0;
    endtask

    initial
    begin
        logic [CFG_DATA_W-1:0] count;
        logic [CFG_DATA_W-1:0] cap;
        int                    phase;
        int                    phase_end;
        int                    pick;
        int                    len;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset settings: one bucket, no room, so every name is dropped
        send_char('1, 1'b1);
        send_char(BLANK_CHAR, 1'b1);
        drain();

        // Count zero acts as one bucket; a second name finds it full
        configure('0, 11'd1);
        send_char(7'h41, 1'b1);
        send_char(7'h41, 1'b1);
        drain();

        // Count above range clamps to 64, capacity above range to 1024
        write_reg(CFG_BUCKET_COUNT, 11'h4C8);
        write_reg(CFG_BUCKET_CAPACITY, 11'h7FF);
        write_reg(CFG_SPARE_A, 11'h7FF);
        write_reg(CFG_SPARE_B, 11'h555);
        cfg_valid <= 1'b0;
        send_char('0, 1'b1);
        send_char('1, 1'b0);
        send_char(BLANK_CHAR, 1'b0);
        send_char(7'h01, 1'b1);
        send_char(7'h55, 1'b0);
        send_char(7'h55, 1'b1);
        drain();

        // Single-slot buckets: repeated names walk the probe sequence
        configure(11'd64, 11'd1);
        repeat (4) send_char(7'h03, 1'b1);
        send_char(BLANK_CHAR, 1'b0);
        send_char(7'h03, 1'b1);
        drain();

        configure(11'd127, 11'd1025);
        send_char(7'h2A, 1'b1);
        drain();

        // Random phases, each under its own settings
        phase = 0;
        while (chars_sent < CHAR_BUDGET)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 15)
            begin
                case ($urandom_range(0, 4))
                    0: count = '0;
                    1: count = 11'd1;
                    2: count = 11'd64;
                    3: count = 11'd127;
                    default: count = CFG_DATA_W'($urandom_range(0, 2047));
                endcase
            end
            else if (pick < 70)
                count = CFG_DATA_W'($urandom_range(1, 16));
            else
                count = CFG_DATA_W'($urandom_range(1, 64));

            pick = $urandom_range(0, 99);
            if (pick < 10)
                cap = '0;
            else if (pick < 18)
                cap = $urandom_range(0, 1) ? 11'd1024 : CFG_DATA_W'($urandom_range(1025, 2047));
            else
                cap = CFG_DATA_W'($urandom_range(1, 3 + 3 * phase));

            configure(count, cap);
            quiet_phase = ($urandom_range(0, 3) == 0);
            phase_end   = chars_sent + $urandom_range(100, 250);
            while (chars_sent < phase_end)
            begin
                pick = $urandom_range(0, 99);
                if (pick < 80)
                    len = $urandom_range(1, 6);
                else if (pick < 95)
                    len = $urandom_range(7, 16);
                else
                    len = $urandom_range(17, 40);
                send_name(len);
            end
            drain();
            phase++;
        end

        repeat (200) @(posedge clk);
        if (mismatch_total == 0 && placements_pending == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+hdl
hdl/dhbp_pkg.sv
hdl/dhbp_ram.sv
hdl/dhbp_hash_mod.sv
hdl/double_hash_bucket_placement_unit.sv
tb/double_hash_bucket_placement_checker.sv
tb/double_hash_bucket_placement_unit_test.sv
